### rtl/gliding_sine_tone_generator_unit_macros.svh
// assertion macros for the gliding sine tone generator
`ifndef GLIDING_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`define GLIDING_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GSTG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GSTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSTG_ASSERT(lbl, clk, rst, prop, msg)
`define GSTG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/gstg_pkg.sv
// constants, register codes and quarter-wave sine table of the tone generator
package gstg_pkg;

   localparam int MAX_CHANNELS    = 8;
   localparam int SINE_TABLE_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int CHAN_BITS       = 3;
   localparam int QUARTER         = (1 << SINE_TABLE_BITS) / 4;
   localparam int QBITS           = SINE_TABLE_BITS - 2;
   localparam int IDX_LO          = 16 - SINE_TABLE_BITS;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   // register indexes
   localparam logic [2:0] REG_SAMPLE_RATE     = 3'd0;
   localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd1;
   localparam logic [2:0] REG_GAIN_DECAY      = 3'd2;
   localparam logic [2:0] REG_FREQUENCY_DECAY = 3'd3;
   localparam logic [2:0] REG_PLAYING_GAIN    = 3'd4;

   typedef logic [SAMPLE_BITS-2:0] qrom_type [0:QUARTER];

   function automatic logic [63:0] sine_q30(input logic [63:0] x);
      logic [63:0] x2, t3, t5, t7, t9;
      x2 = (x * x) >> 30;
      t3 = ((x * x2) >> 30) / 64'd6;
      t5 = ((t3 * x2) >> 30) / 64'd20;
      t7 = ((t5 * x2) >> 30) / 64'd42;
      t9 = ((t7 * x2) >> 30) / 64'd72;
      return (x - t3) + (t5 - t7) + t9;
   endfunction

   function automatic qrom_type build_qrom();
      qrom_type    rom;
      logic [63:0] amp, pos, s, mag;
      amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
      for (int r = 0; r <= QUARTER; r++) begin
         pos = (64'(r) * TWO_PI_Q30) >> SINE_TABLE_BITS;
         s   = sine_q30(pos);
         mag = (s * amp + (64'd1 << 29)) >> 30;
         if (mag > amp) mag = amp;
         rom[r] = mag[SAMPLE_BITS-2:0];
      end
      return rom;
   endfunction

   localparam qrom_type QROM = build_qrom();

endpackage

### rtl/gliding_sine_tone_generator_unit.sv
// gliding sine tone generator: serial phase, sine lookup, gain and glide sequencer
//
// req channel: one beat per sample tick. tdata = target frequency (signed Q.8 Hz),
// tuser[0] = playing flag, tlast = buffer end marker.
// rsp channel: the sample repeated once per channel. tdata = signed sample,
// tuser[2:0] = channel index, tuser[3] = buffer end on the final copy,
// tlast = final copy of the frame.
// csr port: write-only, csr_addr selects sample rate, channel count, gain decay,
// frequency decay, playing gain; write while the block is idle.
// one beat at a time: the arithmetic runs through one shared bit-serial
// shift-add multiplier and one shared restoring divider, one bit per cycle.
// a tick with a positive frequency runs a multiply and a divide for the
// phase and a multiply for the sample; then, once the period wraps or the
// frequency is not positive, a multiply for each glide that still has a
// distance left and a further divide when the frequency changes and a new
// period is divided out. req_tready is high only while idle. a stalled rsp
// side just holds the current copy; nothing is lost.
// reset: sync, active high; registers to their defaults, frequency -1 Hz,
// gain, time and period zero. no clearing pass.
`include "gliding_sine_tone_generator_unit_macros.svh"

module gliding_sine_tone_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] target_frequency
   input  logic [0:0]  req_tuser,   // [0] playing
   input  logic        req_tlast,   // block_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample
   output logic [3:0]  rsp_tuser,   // [2:0] channel, [3] buffer_end
   output logic        rsp_tlast,   // last_channel
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [17:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_PH_MUL, S_PH_DIV, S_ROM, S_GAIN_MUL, S_TIME, S_TCMP,
      S_FG, S_FG_MUL, S_PER_DIV, S_PER_SET, S_GG, S_GG_MUL, S_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [17:0] rate_ff;
   logic [3:0]  chan_count_ff;
   logic [15:0] gain_decay_ff, freq_decay_ff, play_gain_ff;

   // tone state
   logic signed [23:0] cur_f_ff;
   logic [15:0]        gain_ff;
   logic [35:0]        time_ff, period_ff;

   // latched tick
   logic signed [23:0] tgt_f_ff;
   logic [15:0]        tgt_g_ff;
   logic               blk_ff;
   logic [3:0]         nch_ff;
   logic [2:0]         chan_ff;
   logic [15:0]        sample_ff;
   logic               neg_ff;

   // shared serial multiplier and divider
   logic [59:0] acc_ff, mcand_ff, num_ff;
   logic [23:0] mplier_ff, dvs_ff, rem_ff;
   logic [5:0]  cnt_ff;

   logic [17:0] rate_eff;
   logic [3:0]  nch_clamp;
   logic        cur_pos;
   logic [59:0] acc_add, rnd;
   logic [25:0] trial;
   logic        qbit;
   logic [23:0] rem_next;
   logic [gstg_pkg::SINE_TABLE_BITS-1:0] idx;
   logic [gstg_pkg::QBITS:0] qaddr;
   logic signed [24:0] dfreq;
   logic [24:0]        dfreq_mag, fstep;
   logic signed [23:0] nf;
   logic signed [16:0] dgain;
   logic [16:0]        dgain_mag, gstep;
   logic [15:0]        ng, mval;
   logic               last_copy;

   assign rate_eff  = (rate_ff == 18'd0) ? 18'd1 : rate_ff;
   assign nch_clamp = (chan_count_ff == 4'd0) ? 4'd1 :
                      (chan_count_ff > 4'(gstg_pkg::MAX_CHANNELS)) ?
                      4'(gstg_pkg::MAX_CHANNELS) : chan_count_ff;
   assign cur_pos   = !cur_f_ff[23] && (cur_f_ff != 24'sd0);

   // one bit per cycle
   assign acc_add  = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
   assign rnd      = acc_ff + 60'd32768;
   assign trial    = {1'b0, rem_ff, num_ff[59]} - {2'b00, dvs_ff};
   assign qbit     = !trial[25];
   assign rem_next = qbit ? trial[23:0] : {rem_ff[22:0], num_ff[59]};

   // quarter-wave fold of the table index, odd quarters run backward
   assign idx   = num_ff[gstg_pkg::IDX_LO +: gstg_pkg::SINE_TABLE_BITS];
   assign qaddr = idx[gstg_pkg::QBITS] ?
                  (gstg_pkg::QBITS+1)'(gstg_pkg::QUARTER) -
                  {1'b0, idx[gstg_pkg::QBITS-1:0]} :
                  {1'b0, idx[gstg_pkg::QBITS-1:0]};

   // glide arithmetic
   assign dfreq     = 25'(tgt_f_ff) - 25'(cur_f_ff);
   assign dfreq_mag = dfreq[24] ? 25'(-dfreq) : 25'(dfreq);
   assign fstep     = rnd[40:16];
   assign nf        = (fstep == 25'd0) ? tgt_f_ff :
                      dfreq[24] ? cur_f_ff - 24'(fstep) : cur_f_ff + 24'(fstep);
   assign dgain     = 17'({1'b0, tgt_g_ff}) - 17'({1'b0, gain_ff});
   assign dgain_mag = dgain[16] ? 17'(-dgain) : 17'(dgain);
   assign gstep     = rnd[32:16];
   assign ng        = (gstep == 17'd0) ? tgt_g_ff :
                      dgain[16] ? gain_ff - gstep[15:0] : gain_ff + gstep[15:0];
   assign mval      = rnd[31:16];

   assign last_copy = ({1'b0, chan_ff} + 4'd1) == nch_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tdata  = sample_ff;
   assign rsp_tuser  = {last_copy && blk_ff, chan_ff};
   assign rsp_tlast  = last_copy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rate_ff       <= 18'd48000;
         chan_count_ff <= 4'd1;
         gain_decay_ff <= 16'd60293;
         freq_decay_ff <= 16'd58982;
         play_gain_ff  <= 16'd6554;
         cur_f_ff      <= -24'sd256;
         gain_ff       <= 16'd0;
         time_ff       <= 36'd0;
         period_ff     <= 36'd0;
         chan_ff       <= 3'd0;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_addr)
               gstg_pkg::REG_SAMPLE_RATE:     rate_ff       <= csr_wdata;
               gstg_pkg::REG_CHANNEL_COUNT:   chan_count_ff <= csr_wdata[3:0];
               gstg_pkg::REG_GAIN_DECAY:      gain_decay_ff <= csr_wdata[15:0];
               gstg_pkg::REG_FREQUENCY_DECAY: freq_decay_ff <= csr_wdata[15:0];
               gstg_pkg::REG_PLAYING_GAIN:    play_gain_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  tgt_f_ff <= req_tdata;
                  tgt_g_ff <= req_tuser[0] ? play_gain_ff : 16'd0;
                  blk_ff   <= req_tlast;
                  nch_ff   <= nch_clamp;
                  chan_ff  <= 3'd0;
                  if (cur_pos) begin
                     // phase = f * t / rate
                     acc_ff    <= 60'd0;
                     mcand_ff  <= 60'(time_ff);
                     mplier_ff <= 24'(cur_f_ff[22:0]);
                     state_ff  <= S_PH_MUL;
                  end else begin
                     sample_ff <= 16'd0;
                     state_ff  <= S_TIME;
                  end
               end
            end
            S_PH_MUL: begin
               if (mplier_ff == 24'd0) begin
                  num_ff   <= acc_ff;
                  rem_ff   <= 24'd0;
                  dvs_ff   <= 24'(rate_eff);
                  cnt_ff   <= 6'd0;
                  state_ff <= S_PH_DIV;
               end else begin
                  acc_ff    <= acc_add;
                  mcand_ff  <= {mcand_ff[58:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[23:1]};
               end
            end
            S_PH_DIV: begin
               num_ff <= {num_ff[58:0], qbit};
               rem_ff <= rem_next;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd59) state_ff <= S_ROM;
            end
            S_ROM: begin
               neg_ff    <= idx[gstg_pkg::SINE_TABLE_BITS-1];
               acc_ff    <= 60'd0;
               mcand_ff  <= 60'(gain_ff);
               mplier_ff <= 24'(gstg_pkg::QROM[qaddr]);
               state_ff  <= S_GAIN_MUL;
            end
            S_GAIN_MUL: begin
               if (mplier_ff == 24'd0) begin
                  sample_ff <= neg_ff ? 16'(-mval) : mval;
                  state_ff  <= S_TIME;
               end else begin
                  acc_ff    <= acc_add;
                  mcand_ff  <= {mcand_ff[58:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[23:1]};
               end
            end
            S_TIME: begin
               if (cur_pos) begin
                  time_ff  <= time_ff + 36'd256;
                  state_ff <= S_TCMP;
               end else begin
                  time_ff  <= 36'd0;
                  state_ff <= S_FG;
               end
            end
            S_TCMP: begin
               if (time_ff > period_ff) begin
                  time_ff  <= time_ff - period_ff;
                  state_ff <= S_FG;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_FG: begin
               if (dfreq == 25'sd0) begin
                  state_ff <= S_GG;
               end else begin
                  acc_ff    <= 60'd0;
                  mcand_ff  <= 60'(dfreq_mag);
                  mplier_ff <= 24'(17'h10000 - 17'(freq_decay_ff));
                  state_ff  <= S_FG_MUL;
               end
            end
            S_FG_MUL: begin
               if (mplier_ff == 24'd0) begin
                  if (nf != cur_f_ff) begin
                     cur_f_ff <= nf;
                     if (!nf[23] && nf != 24'sd0) begin
                        num_ff   <= {26'd0, rate_eff, 16'd0};
                        rem_ff   <= 24'd0;
                        dvs_ff   <= nf;
                        cnt_ff   <= 6'd0;
                        state_ff <= S_PER_DIV;
                     end else begin
                        period_ff <= 36'd0;
                        state_ff  <= S_GG;
                     end
                  end else begin
                     state_ff <= S_GG;
                  end
               end else begin
                  acc_ff    <= acc_add;
                  mcand_ff  <= {mcand_ff[58:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[23:1]};
               end
            end
            S_PER_DIV: begin
               num_ff <= {num_ff[58:0], qbit};
               rem_ff <= rem_next;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd59) state_ff <= S_PER_SET;
            end
            S_PER_SET: begin
               period_ff <= num_ff[35:0];
               state_ff  <= S_GG;
            end
            S_GG: begin
               if (dgain == 17'sd0) begin
                  state_ff <= S_EMIT;
               end else begin
                  acc_ff    <= 60'd0;
                  mcand_ff  <= 60'(dgain_mag);
                  mplier_ff <= 24'(17'h10000 - 17'(gain_decay_ff));
                  state_ff  <= S_GG_MUL;
               end
            end
            S_GG_MUL: begin
               if (mplier_ff == 24'd0) begin
                  gain_ff  <= ng;
                  state_ff <= S_EMIT;
               end else begin
                  acc_ff    <= acc_add;
                  mcand_ff  <= {mcand_ff[58:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[23:1]};
               end
            end
            S_EMIT: begin
               // one beat per channel copy
               if (rsp_tready) begin
                  if (last_copy) state_ff <= S_IDLE;
                  else           chan_ff  <= chan_ff + 3'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `GSTG_ASSERT(a_chan_in_range, clock, reset, rsp_tvalid |-> ({1'b0, chan_ff} < nch_ff), "channel beyond count")
   `GSTG_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "accepted while busy")
   `GSTG_ASSERT(a_idle_after_last, clock, reset, (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready, "not idle after last copy")
   `GSTG_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid), "input and output both open")

endmodule
